>>> sv/pdcm_pkg.sv
// Shared types and constants of the plane depth colour map.
package pdcm_pkg;

    // Field widths
    localparam int COL_W     = 12;
    localparam int ROW_W     = 12;
    localparam int CH_W      = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int GAP_W     = 8;
    localparam int PCT_W     = 7;

    // Depth limit of +-200 in Q15.16, and the span of the shifted depth
    localparam int DEPTH_LIM = 200 * 65536;
    localparam int T_W       = 25;
    localparam int T_MAX     = 2 * DEPTH_LIM;

    // Hue scale: floor(3t / (5 * 2^16)) taken as (3t >> 16) / 5 by reciprocal
    localparam int HUE_MAX   = 240;
    localparam int HUE_SEG   = 60;
    localparam int RECIP5    = 13108;

    // Colour arithmetic, in units of 1/600000
    localparam int CH_MAX      = 255;
    localparam int PCT_FULL    = 100;
    localparam int VMAX_K      = 6000;
    localparam int COLOR_HALF  = 300000;
    localparam int COLOR_TOP   = 256 * 600000;
    localparam int DIV_LO      = 9375;
    localparam int RECIP_LO    = 1789;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOPE_X    = 3'd0,
        REG_SLOPE_Y    = 3'd1,
        REG_OFFSET     = 3'd2,
        REG_PIXEL_GAP  = 3'd3,
        REG_SATURATION = 3'd4,
        REG_BRIGHTNESS = 3'd5
    } cfg_reg_e;

    // Hue sextants, named by the colours they run between
    typedef enum logic [2:0] {
        SEXT_RED_YEL = 3'd0,
        SEXT_YEL_GRN = 3'd1,
        SEXT_GRN_CYN = 3'd2,
        SEXT_CYN_BLU = 3'd3,
        SEXT_BLU_MAG = 3'd4,
        SEXT_MAG_RED = 3'd5
    } sextant_e;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_out_t;

endpackage

>>> sv/pdcm_stream_if.sv
// Valid/ready stream channel carrying one payload word per transaction.
interface pdcm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/plane_depth_color_map.sv
// Top level of the plane depth colour map: pixel index in, RGB colour out.
//
//  channel   | dir | payload            | transaction
//  ----------+-----+--------------------+-------------------------------------
//  pixel     | in  | col[11:0] row[11:0]| pixel.valid & pixel.ready
//  color     | out | red green blue [7:0]| color.valid & color.ready
//  cfg       | in  | cfg_index cfg_data | cfg_wen (no wait, no read-back)
//
//  An accepted pixel passes through the stage registers listed below to the
//  output register, the last stage, from which the sink takes its colour; one
//  pixel is taken per cycle, all eleven stages loading together whenever
//  nothing stalls.
//  rst_n clears every stage valid bit and loads the register reset values.
//  A stall on color holds the last stage; each stage still loads while the
//  stage after it is empty or moving, so bubbles close up under back-pressure.
//
//  Stages:
//    1  clamp indices, scale by pixel gap      7  V*255, S*frac, 100-S
//    2  slope products                         8  MAX, MIN/60, ADJ products
//    3  plane sum                              9  MIN, sextant channel select
//    4  clamp depth, shift to 0..400           10 round offset, range flags,
//    5  hue by reciprocal of 5                    quotient estimate
//    6  sextant and fraction of hue            11 quotient correction, clamp
module plane_depth_color_map
    import pdcm_pkg::*;
#(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    pdcm_stream_if.sink          pixel,
    pdcm_stream_if.source        color
);

    localparam int NS = 11;
    localparam int unsigned COL_LAST = MAX_COLS - 1;
    localparam int unsigned ROW_LAST = MAX_ROWS - 1;
    localparam logic signed [54:0] LIM_Q = 55'(DEPTH_LIM);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0]  slope_x_reg;
    logic signed [31:0]  slope_y_reg;
    logic signed [31:0]  offset_reg;
    logic [GAP_W-1:0]    gap_reg;
    logic [PCT_W-1:0]    sat_reg;
    logic [PCT_W-1:0]    bright_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_x_reg <= '0;
            slope_y_reg <= '0;
            offset_reg  <= '0;
            gap_reg     <= GAP_W'(1);
            sat_reg     <= PCT_W'(PCT_FULL);
            bright_reg  <= PCT_W'(PCT_FULL);
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_SLOPE_X:    slope_x_reg <= $signed(cfg_data);
                REG_SLOPE_Y:    slope_y_reg <= $signed(cfg_data);
                REG_OFFSET:     offset_reg  <= $signed(cfg_data);
                REG_PIXEL_GAP:  gap_reg     <= cfg_data[GAP_W-1:0];
                REG_SATURATION: sat_reg     <= cfg_data[PCT_W-1:0];
                REG_BRIGHTNESS: bright_reg  <= cfg_data[PCT_W-1:0];
                default:        ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and load enables
    // A stage loads when it is empty or the stage after it moves on.
    // ------------------------------------------------------------------
    logic [NS:1]   v_reg;
    logic [NS+1:1] en;

    always_comb
    begin
        en[NS+1] = color.ready;
        for (int k = NS; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (en[NS:1] & {v_reg[NS-1:1], pixel.valid}) | (~en[NS:1] & v_reg);
        end
    end

    assign pixel.ready = en[1];

    // ------------------------------------------------------------------
    // Stage 1: clamp the indices to the raster and scale by the pixel gap
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_c;
    logic [ROW_W-1:0] row_c;
    logic [19:0]      px_next, py_next;
    logic [19:0]      px_reg, py_reg;

    always_comb
    begin
        col_c = (32'(pixel.data.col) > COL_LAST) ? COL_W'(COL_LAST) : pixel.data.col;
        row_c = (32'(pixel.data.row) > ROW_LAST) ? ROW_W'(ROW_LAST) : pixel.data.row;
        px_next = {8'd0, col_c} * {12'd0, gap_reg};
        py_next = {8'd0, row_c} * {12'd0, gap_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: slope products, Q15.16 times integer position
    // ------------------------------------------------------------------
    logic signed [52:0] mx_next, my_next;
    logic signed [52:0] mx_reg, my_reg;

    always_comb
    begin
        mx_next = 53'(slope_x_reg) * 53'($signed({1'b0, px_reg}));
        my_next = 53'(slope_y_reg) * 53'($signed({1'b0, py_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            mx_reg <= mx_next;
            my_reg <= my_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: plane depth sum
    // ------------------------------------------------------------------
    logic signed [54:0] depth_next;
    logic signed [54:0] depth_reg;

    assign depth_next = 55'(mx_reg) + 55'(my_reg) + 55'(offset_reg);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            depth_reg <= depth_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: clamp to +-200 and shift to 0..400 (still Q16)
    // ------------------------------------------------------------------
    logic [T_W-1:0] t_next;
    logic [T_W-1:0] t_reg;

    always_comb
    begin
        if (depth_reg > LIM_Q)
        begin
            t_next = T_W'(T_MAX);
        end
        else if (depth_reg < -LIM_Q)
        begin
            t_next = '0;
        end
        else
        begin
            t_next = T_W'(depth_reg + LIM_Q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            t_reg <= t_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: hue = 240 - floor((3t >> 16) / 5); the reciprocal is exact
    // for numerators up to 1200.
    // ------------------------------------------------------------------
    logic [26:0] t3;
    logic [10:0] n5;
    logic [24:0] q5p;
    logic [7:0]  hue_next;
    logic [7:0]  hue_reg;

    always_comb
    begin
        t3       = {2'b0, t_reg} + {1'b0, t_reg, 1'b0};
        n5       = t3[26:16];
        q5p      = 25'(n5) * 25'(RECIP5);
        hue_next = 8'(HUE_MAX) - q5p[23:16];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            hue_reg <= hue_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: sextant and position within it
    // ------------------------------------------------------------------
    sextant_e   sext6_next, sext6_reg;
    logic [5:0] frac_next, frac_reg;

    always_comb
    begin
        if (hue_reg >= 8'(4 * HUE_SEG))
        begin
            sext6_next = SEXT_BLU_MAG;
            frac_next  = 6'(hue_reg - 8'(4 * HUE_SEG));
        end
        else if (hue_reg >= 8'(3 * HUE_SEG))
        begin
            sext6_next = SEXT_CYN_BLU;
            frac_next  = 6'(hue_reg - 8'(3 * HUE_SEG));
        end
        else if (hue_reg >= 8'(2 * HUE_SEG))
        begin
            sext6_next = SEXT_GRN_CYN;
            frac_next  = 6'(hue_reg - 8'(2 * HUE_SEG));
        end
        else if (hue_reg >= 8'(HUE_SEG))
        begin
            sext6_next = SEXT_YEL_GRN;
            frac_next  = 6'(hue_reg - 8'(HUE_SEG));
        end
        else
        begin
            sext6_next = SEXT_RED_YEL;
            frac_next  = 6'(hue_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            sext6_reg <= sext6_next;
            frac_reg  <= frac_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: V*255, S*frac and 100-S (negative when S is above 100)
    // ------------------------------------------------------------------
    sextant_e           sext7_reg;
    logic [14:0]        bk_next, bk_reg;
    logic [12:0]        sfrac_next, sfrac_reg;
    logic signed [7:0]  smin_next, smin_reg;

    always_comb
    begin
        bk_next    = {8'd0, bright_reg} * 15'(CH_MAX);
        sfrac_next = 13'(sat_reg) * 13'(frac_reg);
        smin_next  = $signed(8'(PCT_FULL) - {1'b0, sat_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            sext7_reg <= sext6_reg;
            bk_reg    <= bk_next;
            sfrac_reg <= sfrac_next;
            smin_reg  <= smin_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: MAX, MIN/60 and ADJ products
    // ------------------------------------------------------------------
    sextant_e           sext8_reg;
    logic [27:0]        vmax_next, vmax_reg;
    logic signed [23:0] pmin_next, pmin_reg;
    logic [27:0]        adj_next, adj_reg;

    always_comb
    begin
        vmax_next = 28'(bk_reg) * 28'(VMAX_K);
        pmin_next = 24'($signed({1'b0, bk_reg})) * 24'(smin_reg);
        adj_next  = 28'(bk_reg) * 28'(sfrac_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            sext8_reg <= sext7_reg;
            vmax_reg  <= vmax_next;
            pmin_reg  <= pmin_next;
            adj_reg   <= adj_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: MIN = 60 * (MIN/60) by shift and subtract, then route the
    // three levels to red, green and blue by sextant
    // ------------------------------------------------------------------
    logic signed [30:0] pmin_x, vmin, vmax_x, adj_x, lo_up, hi_dn;
    logic signed [30:0] x_next [3];
    logic signed [30:0] x_reg  [3];

    always_comb
    begin
        pmin_x = 31'(pmin_reg);
        vmin   = (pmin_x <<< 6) - (pmin_x <<< 2);
        vmax_x = $signed(31'(vmax_reg));
        adj_x  = $signed(31'(adj_reg));
        lo_up  = vmin + adj_x;
        hi_dn  = vmax_x - adj_x;
        case (sext8_reg)
            SEXT_RED_YEL:
            begin
                x_next[0] = vmax_x; x_next[1] = lo_up;  x_next[2] = vmin;
            end
            SEXT_YEL_GRN:
            begin
                x_next[0] = hi_dn;  x_next[1] = vmax_x; x_next[2] = vmin;
            end
            SEXT_GRN_CYN:
            begin
                x_next[0] = vmin;   x_next[1] = vmax_x; x_next[2] = lo_up;
            end
            SEXT_CYN_BLU:
            begin
                x_next[0] = vmin;   x_next[1] = hi_dn;  x_next[2] = vmax_x;
            end
            SEXT_BLU_MAG:
            begin
                x_next[0] = lo_up;  x_next[1] = vmin;   x_next[2] = vmax_x;
            end
            default:
            begin
                x_next[0] = vmax_x; x_next[1] = vmin;   x_next[2] = hi_dn;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            x_reg <= x_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: add the half for rounding, flag both clamps, and estimate
    // floor(y / 600000) = floor((y >> 6) / 9375) by a short reciprocal.
    // The estimate is exact or one low.
    // ------------------------------------------------------------------
    logic signed [30:0] y     [3];
    logic [32:0]        qprod [3];
    logic [21:0]        n_next  [3], n_reg  [3];
    logic [7:0]         q0_next [3], q0_reg [3];
    logic [2:0]         neg_next, neg_reg;
    logic [2:0]         big_next, big_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            y[i]        = x_reg[i] + 31'(COLOR_HALF);
            neg_next[i] = y[i][30];
            big_next[i] = (y[i] >= $signed(31'(COLOR_TOP)));
            n_next[i]   = y[i][27:6];
            qprod[i]    = 33'(n_next[i]) * 33'(RECIP_LO);
            q0_next[i]  = qprod[i][31:24];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            n_reg   <= n_next;
            q0_reg  <= q0_next;
            neg_reg <= neg_next;
            big_reg <= big_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: correct the quotient, clamp to 0..255, hold for the sink
    // ------------------------------------------------------------------
    logic [21:0]     rem [3];
    logic [CH_W-1:0] ch  [3];
    pix_out_t        out_next, out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem[i] = n_reg[i] - 22'(q0_reg[i]) * 22'(DIV_LO);
            if (neg_reg[i])
            begin
                ch[i] = '0;
            end
            else if (big_reg[i])
            begin
                ch[i] = CH_W'(CH_MAX);
            end
            else
            begin
                ch[i] = q0_reg[i] + CH_W'(rem[i] >= 22'(DIV_LO));
            end
        end
        out_next.red   = ch[0];
        out_next.green = ch[1];
        out_next.blue  = ch[2];
    end

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            out_reg <= out_next;
        end
    end

    assign color.valid = v_reg[NS];
    assign color.data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NS] |-> pixel.ready)
        else $error("input stalled with an empty output stage");

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready |=> v_reg[1])
        else $error("accepted pixel missing from first stage");

    a_depth_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[4] |-> (t_reg <= T_W'(T_MAX)))
        else $error("shifted depth beyond clamp span");

    a_frac_in_sextant: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[6] |-> (frac_reg < 6'(HUE_SEG))
                     && ((sext6_reg != SEXT_BLU_MAG) || (frac_reg == '0)))
        else $error("hue fraction out of sextant");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS] && !color.ready |=> v_reg[NS] && $stable(out_reg))
        else $error("output stage changed under stall");

endmodule
